// ----- sv/petr_pkg.sv -----
package petr_pkg;

  localparam int TYPE_W         = 8;
  localparam int FIELD_W        = 16;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int CNT_W          = 3;
  localparam int HELD_RULES     = 4;
  localparam int RULE_W         = 17;
  localparam int AXIS_STAGES    = 5;
  localparam int TERM_W         = 61;
  localparam int SUM_W          = 63;
  localparam int CAP_SHIFT      = 60;
  localparam int ONE_SHIFT      = 24;
  localparam int OUT_TDATA_W    = 16;

  localparam int RULE_SLOTS_DEF = 4;
  localparam int COORD_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RULES_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RULES_SECOND = 3'd5;

  typedef struct packed {
    logic              outside;
    logic [TYPE_W-1:0] dst;
    logic [TYPE_W-1:0] src;
  } rule_t;

endpackage

// ----- sv/petr_axis.sv -----
module petr_axis import petr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic [AXIS_STAGES-1:0] en,
  input  logic [COORD_BITS-1:0]  pos,
  input  logic [FIELD_W-1:0]     centre,
  input  logic [FIELD_W-1:0]     box,
  input  logic [FIELD_W-1:0]     weight,
  output logic [TERM_W-1:0]      term
);

  localparam int EXT    = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int D_W    = EXT + 2;
  localparam int SQ_W   = 2 * EXT;
  localparam int PROD_W = SQ_W + FIELD_W;
  localparam int CMP_W  = (PROD_W > TERM_W) ? PROD_W : TERM_W;
  localparam logic [TERM_W-1:0] CAP = TERM_W'(1) << CAP_SHIFT;

  logic signed [D_W-1:0] d_a;
  logic signed [D_W-1:0] d_b;
  logic signed [D_W-1:0] d_b_next;
  logic signed [D_W-1:0] d_c;
  logic signed [D_W-1:0] d_neg;
  logic signed [D_W-1:0] len_d;
  logic signed [D_W:0]   len_s;
  logic signed [D_W:0]   two_a;
  logic signed [D_W:0]   two_b;
  logic [EXT-1:0]        mag;
  logic [EXT-1:0]        mag_next;
  logic [SQ_W-1:0]       sq;
  logic [CMP_W-1:0]      prod;

  assign len_d = D_W'(box);
  assign len_s = (D_W+1)'(box);

  // Minimum image: fold down when past half the box, then fold up
  assign two_a    = {d_a, 1'b0};
  assign d_b_next = (two_a > len_s) ? (d_a - len_d) : d_a;
  assign two_b    = {d_b, 1'b0};
  assign d_c      = (two_b < -len_s) ? (d_b + len_d) : d_b;
  assign d_neg    = -d_c;
  assign mag_next = d_c[D_W-1] ? d_neg[EXT-1:0] : d_c[EXT-1:0];
  assign prod     = CMP_W'(sq) * CMP_W'(weight);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_a <= D_W'(pos) - D_W'(centre);
    end
    if (en[1]) begin
      d_b <= d_b_next;
    end
    if (en[2]) begin
      mag <= mag_next;
    end
    if (en[3]) begin
      sq <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (en[4]) begin
      term <= (prod > CMP_W'(CAP)) ? CAP : prod[TERM_W-1:0];
    end
  end

endmodule

// ----- sv/petr_rules.sv -----
module petr_rules import petr_pkg::*; #(
  parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  en_sum,
  input  logic                  en_out,
  input  logic [TERM_W-1:0]     term_x,
  input  logic [TERM_W-1:0]     term_y,
  input  logic [TERM_W-1:0]     term_z,
  input  logic [TYPE_W-1:0]     type_in,
  input  logic [CNT_W-1:0]      rule_count,
  input  rule_t [HELD_RULES-1:0] rules,
  output logic [TYPE_W-1:0]     new_type,
  output logic                  matched,
  output logic [CNT_W-1:0]      fire_count
);

  localparam int LIMIT = (RULE_SLOTS < HELD_RULES) ? RULE_SLOTS : HELD_RULES;
  localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << ONE_SHIFT;

  logic [SUM_W-1:0]  sum;
  logic [TYPE_W-1:0] type_s;
  logic [CNT_W-1:0]  active;
  logic [TYPE_W-1:0] type_next;
  logic [CNT_W-1:0]  count_next;

  assign active = (rule_count > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : rule_count;

  // Match on the input type only; the last firing rule wins
  always_comb begin
    logic lt;
    logic gt;
    logic hit;
    lt         = sum < ONE;
    gt         = sum > ONE;
    type_next  = type_s;
    count_next = '0;
    for (int r = 0; r < HELD_RULES; r++) begin
      hit = rules[r].outside ? gt : lt;
      if ((CNT_W'(r) < active) && (rules[r].src == type_s) && hit) begin
        type_next  = rules[r].dst;
        count_next = count_next + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum    <= SUM_W'(term_x) + SUM_W'(term_y) + SUM_W'(term_z);
      type_s <= type_in;
    end
    if (en_out) begin
      new_type   <= type_next;
      matched    <= (count_next != '0);
      fire_count <= count_next;
    end
  end

endmodule

// ----- sv/periodic_ellipsoid_type_remap.sv -----
// Periodic ellipsoid type remap. Takes one particle per transfer (type and
// x, y, z position in unsigned Q8.8) and returns one result per particle:
// the new type, a matched flag and the number of rules that fired. Per axis
// the offset from the configured centre is wrapped by the minimum-image
// rule, squared and scaled by the axis weight; the terms are summed and
// compared with 1.0, and up to four rules are applied in order, the last
// firing rule giving the new type. The datapath is a seven-stage pipeline
// (offset, fold down, fold up and magnitude, square, weight and saturate,
// sum, rule match into the output register). A result is offered on the
// output from the output register. One particle is taken every cycle
// unless back-pressure from the output has filled the stages. Each stage
// advances whenever its successor can take data, so bubbles collapse and
// input keeps flowing while a result waits at the output, until the
// stages fill.
// Write configuration only while the pipeline is empty.
module periodic_ellipsoid_type_remap_core import petr_pkg::*; #(
  parameter int RULE_SLOTS = RULE_SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // particle in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: particle_type, pos_x, pos_y, pos_z, zero pad to whole bytes
  input  logic [((TYPE_W+3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // result out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: new_type[7:0], matched[8], fire_count[11:9], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int NST = AXIS_STAGES + 2;

  // configuration registers
  logic [CFG_W-1:0]          center_xyz;
  logic [CFG_W-1:0]          weight_xyz;
  logic [CFG_W-1:0]          box_xyz;
  logic [CNT_W-1:0]          rule_count;
  logic [2*RULE_W-1:0]       rules_first;
  logic [2*RULE_W-1:0]       rules_second;

  logic [NST-1:0]            vld;
  logic [NST-1:0]            en;
  logic [TYPE_W-1:0]         type_q [AXIS_STAGES];
  logic [TERM_W-1:0]         term [3];
  rule_t [HELD_RULES-1:0]    rules;
  logic [TYPE_W-1:0]         new_type;
  logic                      matched;
  logic [CNT_W-1:0]          fire_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_xyz   <= '0;
      weight_xyz   <= '0;
      box_xyz      <= '0;
      rule_count   <= '0;
      rules_first  <= '0;
      rules_second <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CENTER:       center_xyz   <= cfg_wdata;
        REG_WEIGHT:       weight_xyz   <= cfg_wdata;
        REG_BOX:          box_xyz      <= cfg_wdata;
        REG_RULE_COUNT:   rule_count   <= cfg_wdata[CNT_W-1:0];
        REG_RULES_FIRST:  rules_first  <= cfg_wdata[2*RULE_W-1:0];
        REG_RULES_SECOND: rules_second <= cfg_wdata[2*RULE_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign rules[0] = rules_first[RULE_W-1:0];
  assign rules[1] = rules_first[2*RULE_W-1:RULE_W];
  assign rules[2] = rules_second[RULE_W-1:0];
  assign rules[3] = rules_second[2*RULE_W-1:RULE_W];

  // A stage advances when empty or when the stage after it advances
  always_comb begin
    en[NST-1] = !vld[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Carry the input type alongside the axis stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      type_q[0] <= s_axis_tdata[TYPE_W-1:0];
    end
    for (int k = 1; k < AXIS_STAGES; k++) begin
      if (en[k]) begin
        type_q[k] <= type_q[k-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    petr_axis #(
      .COORD_BITS(COORD_BITS)
    ) u_axis (
      .clk    (clk),
      .en     (en[AXIS_STAGES-1:0]),
      .pos    (s_axis_tdata[TYPE_W + a*COORD_BITS +: COORD_BITS]),
      .centre (center_xyz[a*FIELD_W +: FIELD_W]),
      .box    (box_xyz[a*FIELD_W +: FIELD_W]),
      .weight (weight_xyz[a*FIELD_W +: FIELD_W]),
      .term   (term[a])
    );
  end

  petr_rules #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_rules (
    .clk        (clk),
    .en_sum     (en[AXIS_STAGES]),
    .en_out     (en[AXIS_STAGES+1]),
    .term_x     (term[0]),
    .term_y     (term[1]),
    .term_z     (term[2]),
    .type_in    (type_q[AXIS_STAGES-1]),
    .rule_count (rule_count),
    .rules      (rules),
    .new_type   (new_type),
    .matched    (matched),
    .fire_count (fire_count)
  );

  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata  = OUT_TDATA_W'({fire_count, matched, new_type});

  localparam int LIMIT = (RULE_SLOTS < HELD_RULES) ? RULE_SLOTS : HELD_RULES;

  // Matched flag agrees with the fire count
  a_matched_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (matched == (fire_count != '0)))
    else $error("matched flag disagrees with fire count");

  // Never more firings than rules that can be active
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (fire_count <= CNT_W'(LIMIT)))
    else $error("fire count exceeds active rule limit");

  // An accepted particle occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted particle lost at pipeline entry");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule
